[design/hsl2rgb_pkg.sv]
// Shared constants, types and sector codes for the HSL to RGB converter.
package hsl2rgb_pkg;

  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int CHAN_W  = 8;
  localparam int T_W     = 6;
  localparam int CN_W    = 14;
  localparam int TERM_W  = 21;
  localparam int SUM_W   = 22;
  localparam int Q_W     = 20;
  localparam int RECIP_W = 19;
  localparam int PROD_W  = Q_W + RECIP_W;

  localparam int NUM_STAGES = 5;

  localparam int HUE_TURN  = 360;
  localparam int HUE_SIXTH = 60;
  localparam int HUE_THIRD = 120;
  localparam int HUE_HALF  = 180;
  localparam int HUE_2THRD = 240;
  localparam int HUE_5SIXT = 300;
  localparam int PCT_FULL  = 100;
  localparam int CHAN_FULL = 255;

  // Scale by 255/1200000 = 17/80000: times 17, drop 7 bits, then divide by 625.
  localparam int SCALE_MUL   = 17;
  localparam int SCALE_SHIFT = 7;
  localparam int DIV_625     = 625;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_625   = ((1 << RECIP_SHIFT) + DIV_625 - 1) / DIV_625;

  localparam int C_WEIGHT = 120;
  localparam int L_WEIGHT = 12000;
  localparam int M_WEIGHT = 60;

  typedef logic [2:0] sector_t;
  localparam sector_t SEC_CX0 = 3'd0;
  localparam sector_t SEC_XC0 = 3'd1;
  localparam sector_t SEC_0CX = 3'd2;
  localparam sector_t SEC_0XC = 3'd3;
  localparam sector_t SEC_X0C = 3'd4;
  localparam sector_t SEC_C0X = 3'd5;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  typedef logic [Q_W-1:0] q_t;

endpackage

[design/hsl_to_rgb_convert.sv]
// Top level of the HSL to RGB converter: stage control and datapath wiring.
//
// Input channel: in_valid/in_ready carry hue_degrees (0..511, taken modulo
// 360), sat_percent and light_percent (values above 100 act as 100).
// Output channel: out_valid/out_ready carry red, green and blue, each
// floor((v + m) * 255) of the HSL model, computed exactly in integers.
// One result beat per input beat, in order.
// Pipeline: five registered stages, in order: normalize, chroma, terms,
// route and pre-scale, divide and clamp.
// Throughput: one beat per cycle when not stalled; each stage has its own valid
// bit and loads when it is empty or the stage after it moves, so bubbles collapse.
// Stall: while out_ready is low the held result stays put and the stages
// behind it keep filling; in_ready drops once all five stages are full.
// Reset: clears all valid bits; the pipeline is empty and in_ready is high
// in the first cycle after reset.
module hsl_to_rgb_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]  hue_degrees,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]  sat_percent,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]  light_percent,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] red,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] green,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] blue
);
  import hsl2rgb_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  pipe_ctl_t             ctl;

  sector_t          sector;
  logic [T_W-1:0]   t_ofs;
  logic [CN_W-1:0]  cn;
  logic [PCT_W-1:0] lig;
  q_t               q_r;
  q_t               q_g;
  q_t               q_b;

  always_comb begin
    ctl.load[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ctl.load[k] = !vld[k] || ctl.load[k+1];
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (ctl.load[k]) begin
        vld_next[k] = (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
      end else begin
        vld_next[k] = vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_ready  = ctl.load[0];
  assign out_valid = vld[NUM_STAGES-1];

  hsl2rgb_front u_front (
    .clk           (clk),
    .ctl           (ctl),
    .hue_degrees   (hue_degrees),
    .sat_percent   (sat_percent),
    .light_percent (light_percent),
    .sector        (sector),
    .t_ofs         (t_ofs),
    .cn            (cn),
    .lig           (lig)
  );

  hsl2rgb_mix u_mix (
    .clk    (clk),
    .ctl    (ctl),
    .sector (sector),
    .t_ofs  (t_ofs),
    .cn     (cn),
    .lig    (lig),
    .q_r    (q_r),
    .q_g    (q_g),
    .q_b    (q_b)
  );

  hsl2rgb_scale u_scale_r (
    .clk  (clk),
    .load (ctl.load[NUM_STAGES-1]),
    .q    (q_r),
    .chan (red)
  );

  hsl2rgb_scale u_scale_g (
    .clk  (clk),
    .load (ctl.load[NUM_STAGES-1]),
    .q    (q_g),
    .chan (green)
  );

  hsl2rgb_scale u_scale_b (
    .clk  (clk),
    .load (ctl.load[NUM_STAGES-1]),
    .q    (q_b),
    .chan (blue)
  );

endmodule

[design/hsl2rgb_front.sv]
// Front stages: hue reduction, sector, clamps, then chroma numerator.
module hsl2rgb_front (
  input  logic                         clk,
  input  hsl2rgb_pkg::pipe_ctl_t       ctl,
  input  logic [hsl2rgb_pkg::HUE_W-1:0] hue_degrees,
  input  logic [hsl2rgb_pkg::PCT_W-1:0] sat_percent,
  input  logic [hsl2rgb_pkg::PCT_W-1:0] light_percent,
  output hsl2rgb_pkg::sector_t         sector,
  output logic [hsl2rgb_pkg::T_W-1:0]  t_ofs,
  output logic [hsl2rgb_pkg::CN_W-1:0] cn,
  output logic [hsl2rgb_pkg::PCT_W-1:0] lig
);
  import hsl2rgb_pkg::*;

  logic [HUE_W-1:0] hue_red;
  logic [HUE_W-1:0] hue_mod;
  sector_t          sec_c;
  logic [PCT_W-1:0] sat_c;
  logic [PCT_W-1:0] lig_c;
  logic [PCT_W:0]   lig2;
  logic [PCT_W:0]   lig_dev;
  logic [PCT_W-1:0] span_c;
  logic [T_W-1:0]   t_c;

  sector_t          s1_sector;
  logic [T_W-1:0]   s1_t;
  logic [PCT_W-1:0] s1_span;
  logic [PCT_W-1:0] s1_sat;
  logic [PCT_W-1:0] s1_lig;

  always_comb begin
    hue_red = (hue_degrees >= HUE_W'(HUE_TURN)) ? hue_degrees - HUE_W'(HUE_TURN)
                                                 : hue_degrees;
    priority if (hue_red < HUE_W'(HUE_SIXTH)) begin
      sec_c = SEC_CX0;
    end else if (hue_red < HUE_W'(HUE_THIRD)) begin
      sec_c = SEC_XC0;
    end else if (hue_red < HUE_W'(HUE_HALF)) begin
      sec_c = SEC_0CX;
    end else if (hue_red < HUE_W'(HUE_2THRD)) begin
      sec_c = SEC_0XC;
    end else if (hue_red < HUE_W'(HUE_5SIXT)) begin
      sec_c = SEC_X0C;
    end else begin
      sec_c = SEC_C0X;
    end
    if (hue_red >= HUE_W'(HUE_2THRD)) begin
      hue_mod = hue_red - HUE_W'(HUE_2THRD);
    end else if (hue_red >= HUE_W'(HUE_THIRD)) begin
      hue_mod = hue_red - HUE_W'(HUE_THIRD);
    end else begin
      hue_mod = hue_red;
    end
    t_c = (hue_mod >= HUE_W'(HUE_SIXTH)) ? T_W'(HUE_W'(HUE_THIRD) - hue_mod)
                                          : T_W'(hue_mod);

    sat_c = (sat_percent > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : sat_percent;
    lig_c = (light_percent > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : light_percent;
    lig2  = {lig_c, 1'b0};
    lig_dev = (lig2 >= (PCT_W+1)'(PCT_FULL)) ? lig2 - (PCT_W+1)'(PCT_FULL)
                                              : (PCT_W+1)'(PCT_FULL) - lig2;
    span_c = PCT_W'((PCT_W+1)'(PCT_FULL) - lig_dev);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_sector <= sec_c;
      s1_t      <= t_c;
      s1_span   <= span_c;
      s1_sat    <= sat_c;
      s1_lig    <= lig_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      sector <= s1_sector;
      t_ofs  <= s1_t;
      cn     <= CN_W'(s1_span) * CN_W'(s1_sat);
      lig    <= s1_lig;
    end
  end

endmodule

[design/hsl2rgb_mix.sv]
// Middle stages: C, X and M terms, channel routing and the first scale step.
module hsl2rgb_mix (
  input  logic                         clk,
  input  hsl2rgb_pkg::pipe_ctl_t       ctl,
  input  hsl2rgb_pkg::sector_t         sector,
  input  logic [hsl2rgb_pkg::T_W-1:0]  t_ofs,
  input  logic [hsl2rgb_pkg::CN_W-1:0] cn,
  input  logic [hsl2rgb_pkg::PCT_W-1:0] lig,
  output hsl2rgb_pkg::q_t              q_r,
  output hsl2rgb_pkg::q_t              q_g,
  output hsl2rgb_pkg::q_t              q_b
);
  import hsl2rgb_pkg::*;

  sector_t           s3_sector;
  logic [TERM_W-1:0] cv;
  logic [TERM_W-1:0] xv;
  logic [TERM_W-1:0] mv;

  logic [TERM_W-1:0] r_term;
  logic [TERM_W-1:0] g_term;
  logic [TERM_W-1:0] b_term;

  function automatic q_t scale_pre(input logic [TERM_W-1:0] term,
                                   input logic [TERM_W-1:0] m);
    logic [SUM_W-1:0]       sum;
    logic [SUM_W+4:0]       prod;
    sum  = SUM_W'(term) + SUM_W'(m);
    prod = (SUM_W+5)'(sum) * (SUM_W+5)'(SCALE_MUL);
    return Q_W'(prod >> SCALE_SHIFT);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_sector <= sector;
      cv <= TERM_W'(cn) * TERM_W'(C_WEIGHT);
      xv <= TERM_W'({TERM_W'(cn) * TERM_W'(t_ofs), 1'b0});
      mv <= TERM_W'(lig) * TERM_W'(L_WEIGHT) - TERM_W'(cn) * TERM_W'(M_WEIGHT);
    end
  end

  always_comb begin
    unique case (s3_sector)
      SEC_CX0: begin r_term = cv; g_term = xv; b_term = '0; end
      SEC_XC0: begin r_term = xv; g_term = cv; b_term = '0; end
      SEC_0CX: begin r_term = '0; g_term = cv; b_term = xv; end
      SEC_0XC: begin r_term = '0; g_term = xv; b_term = cv; end
      SEC_X0C: begin r_term = xv; g_term = '0; b_term = cv; end
      SEC_C0X: begin r_term = cv; g_term = '0; b_term = xv; end
      default: begin r_term = '0; g_term = '0; b_term = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      q_r <= scale_pre(r_term, mv);
      q_g <= scale_pre(g_term, mv);
      q_b <= scale_pre(b_term, mv);
    end
  end

endmodule

[design/hsl2rgb_scale.sv]
// Output stage: divide by 625 through a reciprocal multiply, clamp to 8 bits.
module hsl2rgb_scale (
  input  logic                          clk,
  input  logic                          load,
  input  hsl2rgb_pkg::q_t               q,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] chan
);
  import hsl2rgb_pkg::*;

  logic [PROD_W-1:0]             prod;
  logic [PROD_W-RECIP_SHIFT-1:0] quot;

  always_comb begin
    prod = PROD_W'(q) * PROD_W'(RECIP_625);
    quot = prod[PROD_W-1:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chan <= (quot > (PROD_W-RECIP_SHIFT)'(CHAN_FULL)) ? CHAN_W'(CHAN_FULL)
                                                        : CHAN_W'(quot);
    end
  end

endmodule

[design/hsl2rgb_checker.sv]
// Port-level checks for the HSL to RGB converter, bound to the top level.
module hsl2rgb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] red,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] green,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] blue
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
                                && $stable(blue))
    else $error("stalled output beat changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side can move");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready
      ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("beat did not reach output in five cycles");

endmodule

bind hsl_to_rgb_convert hsl2rgb_checker u_hsl2rgb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .red       (red),
  .green     (green),
  .blue      (blue)
);
